### sv/bbpf_pkg.sv
// shared types, constants and codes for the bayer bad pixel fix unit
package bbpf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CFG_DIM_W = 13;
  localparam int NOISE_W = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int COEF_W = 20;
  localparam int ACC_W = SAMPLE_BITS + 24;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_NOISE_LEVEL  = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    FIX_NONE      = 3'd0,
    FIX_GREEN_ONE = 3'd1,
    FIX_GREEN_TWO = 3'd2,
    FIX_RED_AVG   = 3'd3,
    FIX_BLUE_AVG  = 3'd4,
    FIX_UNFIXABLE = 3'd5
  } fix_kind_e;

  typedef struct packed {
    sample_t red_in;
    sample_t green_one_in;
    sample_t green_two_in;
    sample_t blue_in;
  } pix_in_t;

  typedef struct packed {
    sample_t   red_out;
    sample_t   green_one_out;
    sample_t   green_two_out;
    sample_t   blue_out;
    fix_kind_e fix_kind;
    logic      last_of_run;
  } pix_out_t;

  // color matrix in Q16, rows give the three output channels
  localparam logic signed [COEF_W-1:0] COLOR_MAT [3][3] = '{
    '{ 20'sd282992, -20'sd63703,  20'sd7095   },
    '{ -20'sd34136, 20'sd108749,  -20'sd43451 },
    '{ 20'sd6250,   -20'sd34023,  20'sd149274 }
  };

  function automatic sample_t clamp_zero(input sample_t x);
    clamp_zero = x[SAMPLE_BITS-1] ? '0 : x;
  endfunction

  // rounded average of four, division truncating toward zero
  function automatic sample_t avg4(input sample_t a, input sample_t b,
                                   input sample_t c, input sample_t d);
    logic signed [SAMPLE_BITS+2:0] s;
    logic signed [SAMPLE_BITS+2:0] t;
    s = (SAMPLE_BITS+3)'(a) + (SAMPLE_BITS+3)'(b) + (SAMPLE_BITS+3)'(c)
      + (SAMPLE_BITS+3)'(d) + (SAMPLE_BITS+3)'(2);
    t = s[SAMPLE_BITS+2] ? s + (SAMPLE_BITS+3)'(3) : s;
    avg4 = SAMPLE_BITS'(t >>> 2);
  endfunction

endpackage

### sv/bayer_bad_pixel_fix_unit.sv
// top level of the bayer bad pixel fix unit
//
// Takes one RGGB quad per cycle, unless in_stall_o holds it, in raster order
// and returns each quad one frame row later: the transfer of the quad at
// column c of row r releases the corrected quad at column c of row r-1, and
// in the last row also the new quad itself, passed through. In the last row
// each input thus causes two results, which the output port sends one per
// cycle while out_stall_i is low. The previous row lives in a raw line ram
// read one column ahead, so its output doubles as the current column for the
// next transfer; a second ram keeps the corrected red and blue of the row
// above. A result passes the stage 1 and stage 2 registers after its transfer
// and is then written into the output queue.
// Stores need no clearing pass after reset: every entry used was written
// earlier in the same frame. Writing width or height restarts the frame.
module bayer_bad_pixel_fix_unit
  import bbpf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int QDEPTH = 8;
  localparam int QW = $clog2(QDEPTH);

  // configuration
  logic [CFG_DIM_W-1:0] frame_width_q, frame_height_q;
  logic [NOISE_W-1:0]   noise_level_q;
  logic [WW-1:0]        width_used;
  logic [CFG_DIM_W-1:0] height_used;

  always_comb begin
    if (frame_width_q < CFG_DIM_W'(3)) begin
      width_used = WW'(3);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      width_used = WW'(MAX_WIDTH);
    end else begin
      width_used = WW'(frame_width_q);
    end
    if (frame_height_q < CFG_DIM_W'(3)) begin
      height_used = CFG_DIM_W'(3);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      height_used = CFG_DIM_W'(MAX_HEIGHT);
    end else begin
      height_used = frame_height_q;
    end
  end

  // position of the next transfer
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic             at_last_col, at_last_row;
  logic [CW-1:0]    ahead_addr;
  logic             in_accept;

  assign at_last_col = (WW'(col_q) + WW'(1)) == width_used;
  assign at_last_row = (CFG_DIM_W'(row_q) + CFG_DIM_W'(1)) == height_used;
  assign ahead_addr  = at_last_col ? '0 : col_q + CW'(1);

  // output queue bookkeeping
  logic [QW:0] q_cnt_q;
  logic        s1_valid_q, s2_valid_q;
  logic [QW+2:0] room_need;

  // each stage in flight may still add two results
  assign room_need = (QW+3)'(q_cnt_q) + (s1_valid_q ? (QW+3)'(2) : '0)
                   + (s2_valid_q ? (QW+3)'(2) : '0) + (QW+3)'(2);
  assign in_stall_o = room_need > (QW+3)'(QDEPTH);
  assign in_accept  = in_valid_i && !in_stall_o;

  // raw line of the previous row, read one column ahead
  logic [4*SAMPLE_BITS-1:0] pend_rdata;
  bbpf_ram #(
    .WIDTH (4*SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_pend_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (col_q),
    .wdata_i (in_data_i),
    .re_i    (in_accept),
    .raddr_i (ahead_addr),
    .rdata_o (pend_rdata)
  );

  // corrected red and blue of the row above
  logic [2*SAMPLE_BITS-1:0] above_rdata;
  logic                     above_we;
  logic [CW-1:0]            above_waddr;
  logic [2*SAMPLE_BITS-1:0] above_wdata;
  bbpf_ram #(
    .WIDTH (2*SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_above_ram (
    .clk_i   (clk_i),
    .we_i    (above_we),
    .waddr_i (above_waddr),
    .wdata_i (above_wdata),
    .re_i    (in_accept),
    .raddr_i (col_q),
    .rdata_o (above_rdata)
  );

  // stage 1: the transfer just taken, ram reads in flight
  pix_in_t       s1_pix_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_out_q, s1_last_q, s1_inner_q;
  acc_t          s1_thr_q;

  // current column of the previous row, captured from the look-ahead read
  pix_in_t       cur_q;

  // stage 2: products registered, correction decided
  pix_in_t       s2_pix_q, s2_raw_q;
  logic [CW-1:0] s2_col_q;
  logic          s2_out_q, s2_last_q, s2_inner_q;
  acc_t          s2_thr_q;
  sample_t       s2_cr_q, s2_c1_q, s2_c2_q, s2_cb_q;
  sample_t       s2_right_r_q, s2_right_b_q, s2_above_r_q, s2_above_b_q;
  acc_t          pr_q [3];
  acc_t          pg1_q [3];
  acc_t          pg2_q [3];
  acc_t          pb_q [3];
  pix_out_t      fixed, passed;

  sample_t left_r_q, left_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CFG_DIM_W'(MAX_WIDTH_DEF);
      frame_height_q <= CFG_DIM_W'(MAX_HEIGHT);
      noise_level_q  <= '0;
      col_q          <= '0;
      row_q          <= '0;
      left_r_q       <= '0;
      left_b_q       <= '0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      s2_valid_q <= s1_valid_q;
      if (cfg_we_i) begin
        unique case (cfg_index_e'(cfg_index_i))
          CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
            if (cfg_index_e'(cfg_index_i) == CFG_FRAME_WIDTH) begin
              frame_width_q <= cfg_data_i[CFG_DIM_W-1:0];
            end else begin
              frame_height_q <= cfg_data_i[CFG_DIM_W-1:0];
            end
            // frame restart
            col_q    <= '0;
            row_q    <= '0;
            left_r_q <= '0;
            left_b_q <= '0;
          end
          CFG_NOISE_LEVEL: noise_level_q <= cfg_data_i[NOISE_W-1:0];
          default: ;
        endcase
      end else begin
        if (in_accept) begin
          if (at_last_col) begin
            col_q <= '0;
            row_q <= at_last_row ? '0 : row_q + ROW_W'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        if (s2_valid_q && s2_out_q) begin
          left_r_q <= fixed.red_out;
          left_b_q <= fixed.blue_out;
        end
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= in_data_i;
      s1_col_q   <= col_q;
      s1_out_q   <= row_q != '0;
      s1_last_q  <= at_last_row;
      s1_inner_q <= (col_q != '0) && !at_last_col && (row_q >= ROW_W'(2));
      s1_thr_q   <= acc_t'({(NOISE_W+2)'(noise_level_q) * (NOISE_W+2)'(3), 16'h0000});
    end
    if (s1_valid_q) begin
      cur_q        <= pend_rdata;
      s2_pix_q     <= s1_pix_q;
      s2_raw_q     <= cur_q;
      s2_col_q     <= s1_col_q;
      s2_out_q     <= s1_out_q;
      s2_last_q    <= s1_last_q;
      s2_inner_q   <= s1_inner_q;
      s2_thr_q     <= s1_thr_q;
      s2_cr_q      <= clamp_zero(cur_q.red_in);
      s2_c1_q      <= clamp_zero(cur_q.green_one_in);
      s2_c2_q      <= clamp_zero(cur_q.green_two_in);
      s2_cb_q      <= clamp_zero(cur_q.blue_in);
      s2_right_r_q <= pend_rdata[4*SAMPLE_BITS-1 -: SAMPLE_BITS];
      s2_right_b_q <= pend_rdata[SAMPLE_BITS-1:0];
      s2_above_r_q <= above_rdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
      s2_above_b_q <= above_rdata[SAMPLE_BITS-1:0];
      for (int i = 0; i < 3; i++) begin
        pr_q[i]  <= acc_t'(clamp_zero(cur_q.red_in)) * acc_t'(COLOR_MAT[i][0]);
        pg1_q[i] <= acc_t'(clamp_zero(cur_q.green_one_in)) * acc_t'(COLOR_MAT[i][1]);
        pg2_q[i] <= acc_t'(clamp_zero(cur_q.green_two_in)) * acc_t'(COLOR_MAT[i][1]);
        pb_q[i]  <= acc_t'(clamp_zero(cur_q.blue_in)) * acc_t'(COLOR_MAT[i][2]);
      end
    end
  end

  // stage 2 decision: a variant is bad when a product sum plus the
  // threshold magnitude goes negative
  logic     bad1, bad2;
  acc_t     sum1 [3];
  acc_t     sum2 [3];

  always_comb begin
    bad1 = 1'b0;
    bad2 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum1[i] = pr_q[i] + pg1_q[i] + pb_q[i] + s2_thr_q;
      sum2[i] = pr_q[i] + pg2_q[i] + pb_q[i] + s2_thr_q;
      bad1 = bad1 | sum1[i][ACC_W-1];
      bad2 = bad2 | sum2[i][ACC_W-1];
    end

    fixed.red_out       = s2_raw_q.red_in;
    fixed.green_one_out = s2_raw_q.green_one_in;
    fixed.green_two_out = s2_raw_q.green_two_in;
    fixed.blue_out      = s2_raw_q.blue_in;
    fixed.fix_kind      = FIX_NONE;
    fixed.last_of_run   = !s2_last_q;

    if (s2_inner_q) begin
      priority if (bad1 && !bad2) begin
        fixed.green_one_out = s2_c2_q;
        fixed.fix_kind      = FIX_GREEN_ONE;
      end else if (bad2 && !bad1) begin
        fixed.green_two_out = s2_c1_q;
        fixed.fix_kind      = FIX_GREEN_TWO;
      end else if (bad1 && bad2) begin
        priority if (s2_cr_q >= s2_cb_q && s2_cr_q >= s2_c1_q && s2_cr_q >= s2_c2_q) begin
          fixed.red_out  = avg4(s2_above_r_q, left_r_q, s2_right_r_q, s2_pix_q.red_in);
          fixed.fix_kind = FIX_RED_AVG;
        end else if (s2_cb_q >= s2_cr_q && s2_cb_q >= s2_c1_q && s2_cb_q >= s2_c2_q) begin
          fixed.blue_out = avg4(s2_above_b_q, left_b_q, s2_right_b_q, s2_pix_q.blue_in);
          fixed.fix_kind = FIX_BLUE_AVG;
        end else begin
          fixed.fix_kind = FIX_UNFIXABLE;
        end
      end else begin
        fixed.fix_kind = FIX_NONE;
      end
    end

    // last row: the new quad leaves too
    passed.red_out       = s2_pix_q.red_in;
    passed.green_one_out = s2_pix_q.green_one_in;
    passed.green_two_out = s2_pix_q.green_two_in;
    passed.blue_out      = s2_pix_q.blue_in;
    passed.fix_kind      = FIX_NONE;
    passed.last_of_run   = 1'b1;
  end

  assign above_we    = s2_valid_q && s2_out_q;
  assign above_waddr = s2_col_q;
  assign above_wdata = {fixed.red_out, fixed.blue_out};

  // output queue
  pix_out_t    q_mem_q [QDEPTH];
  logic [QW-1:0] q_wr_q, q_rd_q;
  logic        push1, push2, pop;
  logic [1:0]  push_n;

  assign push1  = s2_valid_q && s2_out_q;
  assign push2  = s2_valid_q && s2_last_q;
  assign push_n = {1'b0, push1} + {1'b0, push2};
  assign pop    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push1) begin
      q_mem_q[q_wr_q] <= fixed;
    end
    if (push2) begin
      q_mem_q[push1 ? q_wr_q + QW'(1) : q_wr_q] <= passed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      q_wr_q  <= q_wr_q + QW'(push_n);
      q_rd_q  <= q_rd_q + QW'(pop);
      q_cnt_q <= q_cnt_q + (QW+1)'(push_n) - (QW+1)'(pop);
    end
  end

  assign out_valid_o = q_cnt_q != '0;
  assign out_data_o  = q_mem_q[q_rd_q];

endmodule

### sv/bbpf_ram.sv
// generic single write port ram with registered read
module bbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
